>>> hw/rtl/cie_pkg.sv
package cie_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 20;
  localparam int STATE_W   = 32;
  localparam int COEF_FRAC = 16;
  localparam int SLOT_W    = 20;
  localparam int PACK_W    = 60;
  localparam int NUM_REGS  = 7;
  localparam int NUM_SLOTS = 21;
  localparam int REG_IDX_W = 3;
  localparam int STEP_W    = 5;
  localparam int CIDX_W    = 5;
  localparam int PROD_W    = COEF_W + STATE_W;
  localparam int ACC_W     = 56;

  // The last register holds a single coefficient in its low slot.
  localparam logic [REG_IDX_W-1:0] REG_COEF_PACK_6 = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    SRC_X,
    SRC_XI1,
    SRC_XI2,
    SRC_YO1,
    SRC_YO2,
    SRC_W0,
    SRC_W1,
    SRC_W2,
    SRC_W3,
    SRC_W4,
    SRC_Y1,
    SRC_RI1,
    SRC_RI2,
    SRC_RO1,
    SRC_RO2
  } src_t;

  typedef enum logic [1:0] {
    DST_Y0,
    DST_W0,
    DST_Y1,
    DST_Y2
  } dst_t;

  typedef struct packed {
    logic [CIDX_W-1:0] cidx;
    src_t              src;
    logic              sub;
    logic              first;
    logic              preload;
    logic              last;
    dst_t              dst;
  } mac_op_t;

  function automatic mac_op_t mk(input logic [CIDX_W-1:0] c, input src_t s,
                                 input logic sb, input logic f, input logic p,
                                 input logic l, input dst_t d);
    mac_op_t op;
    op.cidx    = c;
    op.src     = s;
    op.sub     = sb;
    op.first   = f;
    op.preload = p;
    op.last    = l;
    op.dst     = d;
    return op;
  endfunction

  // Microcode for the shared multiply-accumulate unit, one product per step.
  function automatic mac_op_t op_at(input logic [STEP_W-1:0] step);
    mac_op_t op;
    unique case (step)
      5'd0:    op = mk(5'd0,  SRC_X,   1'b0, 1'b1, 1'b0, 1'b0, DST_Y0);
      5'd1:    op = mk(5'd1,  SRC_XI1, 1'b0, 1'b0, 1'b0, 1'b0, DST_Y0);
      5'd2:    op = mk(5'd2,  SRC_XI2, 1'b0, 1'b0, 1'b0, 1'b0, DST_Y0);
      5'd3:    op = mk(5'd3,  SRC_YO1, 1'b1, 1'b0, 1'b0, 1'b0, DST_Y0);
      5'd4:    op = mk(5'd4,  SRC_YO2, 1'b1, 1'b0, 1'b0, 1'b1, DST_Y0);
      5'd5:    op = mk(5'd10, SRC_W1,  1'b1, 1'b1, 1'b1, 1'b0, DST_W0);
      5'd6:    op = mk(5'd11, SRC_W2,  1'b1, 1'b0, 1'b0, 1'b0, DST_W0);
      5'd7:    op = mk(5'd12, SRC_W3,  1'b1, 1'b0, 1'b0, 1'b0, DST_W0);
      5'd8:    op = mk(5'd13, SRC_W4,  1'b1, 1'b0, 1'b0, 1'b1, DST_W0);
      5'd9:    op = mk(5'd5,  SRC_W0,  1'b0, 1'b1, 1'b0, 1'b0, DST_Y1);
      5'd10:   op = mk(5'd6,  SRC_W1,  1'b0, 1'b0, 1'b0, 1'b0, DST_Y1);
      5'd11:   op = mk(5'd7,  SRC_W2,  1'b0, 1'b0, 1'b0, 1'b0, DST_Y1);
      5'd12:   op = mk(5'd8,  SRC_W3,  1'b0, 1'b0, 1'b0, 1'b0, DST_Y1);
      5'd13:   op = mk(5'd9,  SRC_W4,  1'b0, 1'b0, 1'b0, 1'b1, DST_Y1);
      5'd14:   op = mk(5'd14, SRC_Y1,  1'b0, 1'b1, 1'b0, 1'b0, DST_Y2);
      5'd15:   op = mk(5'd15, SRC_RI1, 1'b0, 1'b0, 1'b0, 1'b0, DST_Y2);
      5'd16:   op = mk(5'd16, SRC_RI2, 1'b0, 1'b0, 1'b0, 1'b0, DST_Y2);
      5'd17:   op = mk(5'd17, SRC_RO1, 1'b1, 1'b0, 1'b0, 1'b0, DST_Y2);
      5'd18:   op = mk(5'd18, SRC_RO2, 1'b1, 1'b0, 1'b0, 1'b1, DST_Y2);
      default: op = mk(5'd0,  SRC_X,   1'b0, 1'b0, 1'b0, 1'b1, DST_Y2);
    endcase
    return op;
  endfunction

endpackage

>>> hw/rtl/cascaded_iir_eq_filter.sv
// Three IIR sections in a row (direct form I biquad, direct form II fourth-order
// section, direct form I resonator) share one 20x32 multiplier and a 56-bit
// accumulator. A sample is taken only while the block is idle; the 19 products
// go through the multiplier one per cycle in the run state, and each of the
// four sums (the fourth-order section forms two) adds a drain state and a
// round-and-saturate state after its last product. The output state moves
// the result into the output register and the block returns to idle. The
// output register lets the next sample start while a result still waits; a
// result waits in the last state if the previous one has not been taken.
// Coefficients are Q4.16, three to a configuration register (one in the
// last); any write to one of the seven registers clears all filter history.
module cascaded_iir_eq_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [cie_pkg::SAMPLE_W-1:0]        s_tdata,    // [23:0] in_sample
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cie_pkg::SAMPLE_W-1:0]        m_tdata,    // [23:0] out_sample
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cie_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [cie_pkg::PACK_W-1:0]          cfg_data
);
  import cie_pkg::*;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC - 1);

  state_t state, state_next;
  logic [STEP_W-1:0] step;
  mac_op_t cur_op, pend_op;
  logic pend_valid;
  logic load_out, cfg_write;

  logic [PACK_W-1:0] coef_pack [NUM_REGS];
  logic signed [COEF_W-1:0] coefs [NUM_SLOTS];
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [STATE_W-1:0] opnd;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc, acc_base, acc_next, rnd, quo;
  logic signed [STATE_W-1:0] fin_val;
  logic [SAMPLE_W-1:0] out_sat;

  logic signed [STATE_W-1:0] x_reg, y0, w0, y1, y2;
  logic signed [STATE_W-1:0] first_in_hist [2];
  logic signed [STATE_W-1:0] first_out_hist [2];
  logic signed [STATE_W-1:0] fourth_delay_line [4];
  logic signed [STATE_W-1:0] res_in_hist [2];
  logic signed [STATE_W-1:0] res_out_hist [2];

  assign cur_op    = op_at(step);
  assign cfg_write = cfg_valid && cfg_ready && (cfg_index < REG_IDX_W'(NUM_REGS));

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      coefs[i] = coef_pack[i / 3][(i % 3) * SLOT_W +: COEF_W];
    end
  end
  assign coef_sel = coefs[cur_op.cidx];

  always_comb begin
    case (cur_op.src)
      SRC_X:   opnd = x_reg;
      SRC_XI1: opnd = first_in_hist[0];
      SRC_XI2: opnd = first_in_hist[1];
      SRC_YO1: opnd = first_out_hist[0];
      SRC_YO2: opnd = first_out_hist[1];
      SRC_W0:  opnd = w0;
      SRC_W1:  opnd = fourth_delay_line[0];
      SRC_W2:  opnd = fourth_delay_line[1];
      SRC_W3:  opnd = fourth_delay_line[2];
      SRC_W4:  opnd = fourth_delay_line[3];
      SRC_Y1:  opnd = y1;
      SRC_RI1: opnd = res_in_hist[0];
      SRC_RI2: opnd = res_in_hist[1];
      SRC_RO1: opnd = res_out_hist[0];
      SRC_RO2: opnd = res_out_hist[1];
      default: opnd = '0;
    endcase
  end

  // The fourth-order section starts from y0 scaled up by the coefficient LSB.
  always_comb begin
    if (pend_op.first) begin
      acc_base = pend_op.preload ? (ACC_W'(y0) <<< COEF_FRAC) : '0;
    end else begin
      acc_base = acc;
    end
    acc_next = pend_op.sub ? (acc_base - ACC_W'(prod)) : (acc_base + ACC_W'(prod));
  end

  // Round half up to the state LSB, then saturate to the state width; y2 is saturated to the sample width for output.
  always_comb begin
    rnd = acc + RND_HALF;
    quo = rnd >>> COEF_FRAC;
    if ((&quo[ACC_W-1:STATE_W-1]) || !(|quo[ACC_W-1:STATE_W-1])) begin
      fin_val = quo[STATE_W-1:0];
    end else begin
      fin_val = quo[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    end
    if ((&y2[STATE_W-1:SAMPLE_W-1]) || !(|y2[STATE_W-1:SAMPLE_W-1])) begin
      out_sat = y2[SAMPLE_W-1:0];
    end else begin
      out_sat = y2[STATE_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_RUN;
      ST_RUN:   if (cur_op.last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_FIN;
      ST_FIN:   state_next = (pend_op.dst == DST_Y2) ? ST_OUT : ST_RUN;
      ST_OUT:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
    load_out  = (state == ST_OUT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) coef_pack[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        first_in_hist[i]  <= '0;
        first_out_hist[i] <= '0;
        res_in_hist[i]    <= '0;
        res_out_hist[i]   <= '0;
      end
      for (int i = 0; i < 4; i++) fourth_delay_line[i] <= '0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == ST_RUN);
      if (state == ST_IDLE) begin
        step <= '0;
      end else if (state == ST_RUN) begin
        step <= step + STEP_W'(1);
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_write) begin
        if (cfg_index == REG_COEF_PACK_6) begin
          coef_pack[cfg_index] <= {{(PACK_W-SLOT_W){1'b0}}, cfg_data[SLOT_W-1:0]};
        end else begin
          coef_pack[cfg_index] <= cfg_data;
        end
        for (int i = 0; i < 2; i++) begin
          first_in_hist[i]  <= '0;
          first_out_hist[i] <= '0;
          res_in_hist[i]    <= '0;
          res_out_hist[i]   <= '0;
        end
        for (int i = 0; i < 4; i++) fourth_delay_line[i] <= '0;
      end else if (load_out) begin
        first_in_hist[1]     <= first_in_hist[0];
        first_in_hist[0]     <= x_reg;
        first_out_hist[1]    <= first_out_hist[0];
        first_out_hist[0]    <= y0;
        fourth_delay_line[3] <= fourth_delay_line[2];
        fourth_delay_line[2] <= fourth_delay_line[1];
        fourth_delay_line[1] <= fourth_delay_line[0];
        fourth_delay_line[0] <= w0;
        res_in_hist[1]       <= res_in_hist[0];
        res_in_hist[0]       <= y1;
        res_out_hist[1]      <= res_out_hist[0];
        res_out_hist[0]      <= y2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      x_reg <= STATE_W'($signed(s_tdata));
    end
    if (state == ST_RUN) begin
      prod    <= coef_sel * opnd;
      pend_op <= cur_op;
    end
    if (pend_valid) begin
      acc <= acc_next;
    end
    if (state == ST_FIN) begin
      case (pend_op.dst)
        DST_Y0: y0 <= fin_val;
        DST_W0: w0 <= fin_val;
        DST_Y1: y1 <= fin_val;
        DST_Y2: y2 <= fin_val;
        default: y2 <= fin_val;
      endcase
    end
    if (load_out) begin
      m_tdata <= out_sat;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_RUN && step == '0)
    else $error("sample accepted but sequencer did not start at step zero");

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> pend_valid && pend_op.last)
    else $error("drain cycle without the last product of a section pending");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_OUT)
    else $error("output word appeared without finishing the sequence");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> first_in_hist[0] == '0 && fourth_delay_line[0] == '0
                  && res_out_hist[0] == '0)
    else $error("configuration write did not clear filter history");
`endif

endmodule
